// File: hw/rtl/bbd_pkg.sv
package bbd_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W   = 8;
   localparam int COORD_W = 12;   // fixed width of out_col / out_row
   localparam int SIZE_W  = 13;   // width of the frame size registers
   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int CSUM_W  = 10;   // sum of three pixels
   localparam int SUM_W   = 12;   // sum of nine pixels
   localparam int NUM_RES = 4;    // results one item can cause
   localparam int CNT_W   = 3;

   // floor(s / 9) == (s * 3641) >> 15 for every s up to 9 * 255
   localparam int RECIP_W  = 12;
   localparam int RECIP    = 3641;
   localparam int RECIP_SH = 15;

   localparam int IDX_W = 2;
   localparam logic [IDX_W-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_DECIMATE_MODE = 2'd2;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

   typedef struct packed {
      logic               decim;
      logic [COORD_W-1:0] wm1;      // last column
      logic [COORD_W-1:0] hm1;      // last row
      logic [COORD_W-1:0] half_w;
      logic [COORD_W-1:0] half_h;
      logic [COORD_W-1:0] lastx;    // column of the frame's last center
      logic [COORD_W-1:0] lasty;
   } geom_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [PIX_W-1:0]   pix;
      logic               x_ge1;
      logic               x_is1;
      logic               x_last;
      logic               y_ge1;
      logic               y_is1;
      logic               y_last;
   } s1_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last;
   } res_type;

endpackage

// File: hw/rtl/bbd_req_if.sv
interface bbd_req_if;
   logic                       valid;
   logic                       ready;
   logic [bbd_pkg::PIX_W-1:0]  pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

// File: hw/rtl/bbd_rsp_if.sv
interface bbd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bbd_pkg::PIX_W-1:0]    pixel_out;
   logic [bbd_pkg::COORD_W-1:0]  out_col;
   logic [bbd_pkg::COORD_W-1:0]  out_row;
   logic                         frame_last;

   modport source (output valid, output pixel_out, output out_col, output out_row,
                   output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input out_col, input out_row,
                   input frame_last, output ready);
endinterface

// File: hw/rtl/bbd_line_store.sv
// Both line stores in one word: [2*PIX_W-1:PIX_W] two rows up, [PIX_W-1:0] one row up.
module bbd_line_store (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [bbd_pkg::ADDR_W-1:0]    rd_addr,
   output logic [2*bbd_pkg::PIX_W-1:0]   rd_data,
   input  logic                          wr_en,
   input  logic [bbd_pkg::ADDR_W-1:0]    wr_addr,
   input  logic [2*bbd_pkg::PIX_W-1:0]   wr_data
);

   logic [2*bbd_pkg::PIX_W-1:0] line_mem [bbd_pkg::MAX_WIDTH];
   logic [2*bbd_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // data holds while no new read is issued, so a stalled item keeps its rows
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bbd_window.sv
module bbd_window (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  bbd_pkg::s1_type             s1,
   input  logic [bbd_pkg::PIX_W-1:0]   p1,
   input  logic [bbd_pkg::PIX_W-1:0]   p2,
   input  bbd_pkg::geom_type           geom,
   output bbd_pkg::res_type            cand [bbd_pkg::NUM_RES],
   output logic [bbd_pkg::NUM_RES-1:0] cand_vld
);

   localparam int PW = bbd_pkg::PIX_W;
   localparam int CW = bbd_pkg::COORD_W;
   localparam int SW = bbd_pkg::SUM_W;
   localparam int KW = bbd_pkg::CSUM_W;

   // [0..2] column x-1 top/mid/bot, [3..5] column x-2
   logic [PW-1:0] win_ff [6];
   logic [PW-1:0] win_in [6];

   logic [PW-1:0] c0 [3];
   logic [PW-1:0] c1 [3];
   logic [PW-1:0] c2 [3];
   logic [KW-1:0] cs0n, cs1n, cs2n, cs0b, cs1b, cs2b;
   logic [SW-1:0] sum  [bbd_pkg::NUM_RES];
   logic [CW-1:0] cx   [bbd_pkg::NUM_RES];
   logic [CW-1:0] cy   [bbd_pkg::NUM_RES];
   logic [bbd_pkg::NUM_RES-1:0] keep;
   logic [bbd_pkg::NUM_RES-1:0] base;

   function automatic logic [KW-1:0] col_sum(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                            input logic [PW-1:0] c);
      col_sum = KW'(a) + KW'(b) + KW'(c);
   endfunction

   always_comb begin
      c2[0] = s1.y_is1 ? p1 : p2;
      c2[1] = p1;
      c2[2] = s1.pix;
      for (int r = 0; r < 3; r++) begin
         c1[r] = win_ff[r];
         c0[r] = s1.x_is1 ? win_ff[r] : win_ff[3 + r];
      end
   end

   // bottom-row centers repeat the lowest row in place of the row below
   always_comb begin
      cs0n = col_sum(c0[0], c0[1], c0[2]);
      cs1n = col_sum(c1[0], c1[1], c1[2]);
      cs2n = col_sum(c2[0], c2[1], c2[2]);
      cs0b = col_sum(c0[1], c0[2], c0[2]);
      cs1b = col_sum(c1[1], c1[2], c1[2]);
      cs2b = col_sum(c2[1], c2[2], c2[2]);
      sum[0] = SW'(cs0n) + SW'(cs1n) + SW'(cs2n);
      sum[1] = SW'(cs1n) + SW'(cs2n) + SW'(cs2n);
      sum[2] = SW'(cs0b) + SW'(cs1b) + SW'(cs2b);
      sum[3] = SW'(cs1b) + SW'(cs2b) + SW'(cs2b);
      cx[0] = s1.x - CW'(1);
      cy[0] = s1.y - CW'(1);
      cx[1] = s1.x;
      cy[1] = s1.y - CW'(1);
      cx[2] = s1.x - CW'(1);
      cy[2] = s1.y;
      cx[3] = s1.x;
      cy[3] = s1.y;
      base[0] = s1.y_ge1 && s1.x_ge1;
      base[1] = s1.y_ge1 && s1.x_last;
      base[2] = s1.y_ge1 && s1.y_last && s1.x_ge1;
      base[3] = s1.y_ge1 && s1.y_last && s1.x_last;
   end

   always_comb begin
      for (int i = 0; i < bbd_pkg::NUM_RES; i++) begin
         keep[i] = !geom.decim ||
                   (!cx[i][0] && !cy[i][0] &&
                    ({1'b0, cx[i][CW-1:1]} < geom.half_w) &&
                    ({1'b0, cy[i][CW-1:1]} < geom.half_h));
         cand[i].sum  = sum[i];
         cand[i].col  = geom.decim ? {1'b0, cx[i][CW-1:1]} : cx[i];
         cand[i].row  = geom.decim ? {1'b0, cy[i][CW-1:1]} : cy[i];
         cand[i].last = (cx[i] == geom.lastx) && (cy[i] == geom.lasty);
         cand_vld[i]  = base[i] && keep[i];
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r]     = win_ff[r];
         win_in[3 + r] = win_ff[3 + r];
      end
      if (fire) begin
         for (int r = 0; r < 3; r++) begin
            win_in[3 + r] = win_ff[r];
            win_in[r]     = c2[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

// File: hw/rtl/bbd_result_queue.sv
module bbd_result_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  bbd_pkg::res_type            cand [bbd_pkg::NUM_RES],
   input  logic [bbd_pkg::NUM_RES-1:0] cand_vld,
   output logic                        room,
   bbd_rsp_if.source                   rsp_bus
);

   localparam int NW = bbd_pkg::CNT_W;
   localparam int PRODW = bbd_pkg::SUM_W + bbd_pkg::RECIP_W;

   bbd_pkg::res_type slot_ff [bbd_pkg::NUM_RES];
   bbd_pkg::res_type slot_in [bbd_pkg::NUM_RES];
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic [NW-1:0]    rd_ff, rd_in;
   logic [NW-1:0]    k;

   logic                         out_vld_ff, out_vld_in;
   logic [bbd_pkg::PIX_W-1:0]    out_pix_ff, out_pix_in;
   logic [bbd_pkg::COORD_W-1:0]  out_col_ff, out_col_in;
   logic [bbd_pkg::COORD_W-1:0]  out_row_ff, out_row_in;
   logic                         out_last_ff, out_last_in;

   bbd_pkg::res_type head;
   logic [PRODW-1:0] prod;
   logic             pop;
   logic             empty;

   assign empty = (rd_ff == cnt_ff);
   assign pop   = !empty && (!out_vld_ff || rsp_bus.ready);
   assign room  = empty || (((rd_ff + NW'(1)) == cnt_ff) && pop);

   assign head = slot_ff[rd_ff[1:0]];
   assign prod = PRODW'(head.sum) * PRODW'(bbd_pkg::RECIP);

   // pack the kept results into the front slots, in order
   always_comb begin
      k = '0;
      for (int j = 0; j < bbd_pkg::NUM_RES; j++) begin
         slot_in[j] = slot_ff[j];
      end
      if (load) begin
         for (int i = 0; i < bbd_pkg::NUM_RES; i++) begin
            if (cand_vld[i]) begin
               slot_in[k[1:0]] = cand[i];
               k = k + NW'(1);
            end
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (load && (k != '0)) begin
         cnt_in = k;
         rd_in  = '0;
      end else if (pop) begin
         rd_in = rd_ff + NW'(1);
      end
   end

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_pix_in  = out_pix_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_last_in = out_last_ff;
      if (pop) begin
         out_vld_in  = 1'b1;
         out_pix_in  = prod[bbd_pkg::RECIP_SH +: bbd_pkg::PIX_W];
         out_col_in  = head.col;
         out_row_in  = head.row;
         out_last_in = head.last;
      end else if (rsp_bus.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         rd_ff      <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         rd_ff      <= rd_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < bbd_pkg::NUM_RES; j++) begin
         slot_ff[j] <= slot_in[j];
      end
      out_pix_ff  <= out_pix_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid      = out_vld_ff;
   assign rsp_bus.pixel_out  = out_pix_ff;
   assign rsp_bus.out_col    = out_col_ff;
   assign rsp_bus.out_row    = out_row_ff;
   assign rsp_bus.frame_last = out_last_ff;

endmodule

// File: hw/rtl/box_blur_3x3_decimate.sv
// 3x3 box blur with edge clamping and optional 2x decimation, for 8-bit grey
// pixels in raster order. One pixel is accepted per clock while the result
// queue has room. Each item reads its column (previous and second previous
// row) from a single line store word and writes it back when the item leaves
// the compute stage. The 3x3 sums go to a four-entry result queue, then an
// output register; the queue drains one result per clock while the output
// is taken. An item on the last row past its first column causes up to four
// results and can hold the input until the queue has room; the results of a
// last-column item drain while the first pixels of the next row, which cause
// none, pass without a stall. A stalled output backs up into the input after
// the queue and the output register fill. Any configuration write restarts
// the frame at row 0, column 0; write registers only while the block is idle.
module box_blur_3x3_decimate (
   input  logic                          clock,
   input  logic                          reset,
   bbd_req_if.sink                       req_bus,
   bbd_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [bbd_pkg::IDX_W-1:0]     csr_index,
   input  logic [bbd_pkg::SIZE_W-1:0]    csr_wdata
);

   localparam int CW = bbd_pkg::COORD_W;
   localparam int ZW = bbd_pkg::SIZE_W;
   localparam int PW = bbd_pkg::PIX_W;
   localparam logic [ZW-1:0] MIN_SIZE = ZW'(2);
   localparam logic [ZW-1:0] MAX_W    = ZW'(bbd_pkg::MAX_WIDTH);
   localparam logic [ZW-1:0] MAX_H    = ZW'(bbd_pkg::MAX_HEIGHT);

   logic [ZW-1:0] width_ff, width_in;
   logic [ZW-1:0] height_ff, height_in;
   logic          decim_ff, decim_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;

   bbd_pkg::s1_type s1_ff, s1_in;
   logic            s1_vld_ff, s1_vld_in;

   logic [ZW-1:0] w_eff, h_eff, w_even, h_even;
   bbd_pkg::geom_type geom;

   logic            accept;
   logic            s1_fire;
   logic            room;
   logic [2*PW-1:0] rd_data;

   bbd_pkg::res_type            cand [bbd_pkg::NUM_RES];
   logic [bbd_pkg::NUM_RES-1:0] cand_vld;

   always_comb begin
      w_eff = (width_ff < MIN_SIZE) ? MIN_SIZE : (width_ff > MAX_W) ? MAX_W : width_ff;
      h_eff = (height_ff < MIN_SIZE) ? MIN_SIZE : (height_ff > MAX_H) ? MAX_H : height_ff;
      w_even = {w_eff[ZW-1:1], 1'b0};
      h_even = {h_eff[ZW-1:1], 1'b0};
      geom.decim  = decim_ff;
      geom.wm1    = CW'(w_eff - ZW'(1));
      geom.hm1    = CW'(h_eff - ZW'(1));
      geom.half_w = w_eff[ZW-1:1];
      geom.half_h = h_eff[ZW-1:1];
      geom.lastx  = decim_ff ? CW'(w_even - ZW'(2)) : CW'(w_eff - ZW'(1));
      geom.lasty  = decim_ff ? CW'(h_even - ZW'(2)) : CW'(h_eff - ZW'(1));
   end

   assign s1_fire       = s1_vld_ff && ((cand_vld == '0) || room);
   assign req_bus.ready = !s1_vld_ff || s1_fire;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      decim_in  = decim_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         case (csr_index)
            bbd_pkg::CSR_FRAME_WIDTH:   width_in  = csr_wdata;
            bbd_pkg::CSR_FRAME_HEIGHT:  height_in = csr_wdata;
            bbd_pkg::CSR_DECIMATE_MODE: decim_in  = csr_wdata[0];
            default: ;
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == geom.wm1) begin
            col_in = '0;
            row_in = (row_ff == geom.hm1) ? '0 : row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_comb begin
      s1_in        = s1_ff;
      s1_vld_in    = s1_vld_ff;
      if (accept) begin
         s1_in.x      = col_ff;
         s1_in.y      = row_ff;
         s1_in.pix    = req_bus.pixel_in;
         s1_in.x_ge1  = (col_ff != '0);
         s1_in.x_is1  = (col_ff == CW'(1));
         s1_in.x_last = (col_ff == geom.wm1);
         s1_in.y_ge1  = (row_ff != '0);
         s1_in.y_is1  = (row_ff == CW'(1));
         s1_in.y_last = (row_ff == geom.hm1);
         s1_vld_in    = 1'b1;
      end else if (s1_fire) begin
         s1_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bbd_pkg::WIDTH_RESET;
         height_ff <= bbd_pkg::HEIGHT_RESET;
         decim_ff  <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         decim_ff  <= decim_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // consecutive items always touch different columns, so no forwarding is needed
   bbd_line_store u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (bbd_pkg::ADDR_W'(col_ff)),
      .rd_data (rd_data),
      .wr_en   (s1_fire),
      .wr_addr (bbd_pkg::ADDR_W'(s1_ff.x)),
      .wr_data ({rd_data[PW-1:0], s1_ff.pix})
   );

   bbd_window u_window (
      .clock    (clock),
      .reset    (reset),
      .fire     (s1_fire),
      .s1       (s1_ff),
      .p1       (rd_data[PW-1:0]),
      .p2       (rd_data[2*PW-1:PW]),
      .geom     (geom),
      .cand     (cand),
      .cand_vld (cand_vld)
   );

   bbd_result_queue u_result_queue (
      .clock    (clock),
      .reset    (reset),
      .load     (s1_fire),
      .cand     (cand),
      .cand_vld (cand_vld),
      .room     (room),
      .rsp_bus  (rsp_bus)
   );

endmodule

// File: tb/tb_box_blur_3x3_decimate.sv
module tb_box_blur_3x3_decimate;

   localparam logic [bbd_pkg::IDX_W-1:0] CSR_NO_REG = 2'd3;   // unmapped, still restarts the frame
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned STALL_LIMIT    = 2000;
   localparam int unsigned RANDOM_ITEMS   = 120;
   localparam int unsigned OVERSIZE_ITEMS = 16;
   localparam int unsigned DIR_ROWS       = 44;

   // pixel content of a phase
   localparam int unsigned FILL_RANDOM  = 0;
   localparam int unsigned FILL_WHITE   = 1;
   localparam int unsigned FILL_BLACK   = 2;
   localparam int unsigned FILL_BILEVEL = 3;

   typedef struct packed {
      logic [bbd_pkg::PIX_W-1:0]   pixel;
      logic [bbd_pkg::COORD_W-1:0] col;
      logic [bbd_pkg::COORD_W-1:0] row;
      logic                        last;
   } blur_result_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_PIX, ROW_PIX_TYPED, ROW_RESULT} dir_kind_type;

   typedef struct packed {
      dir_kind_type                kind;
      logic [bbd_pkg::IDX_W-1:0]   idx;
      logic [bbd_pkg::SIZE_W-1:0]  data;
      logic [bbd_pkg::COORD_W-1:0] col;
      logic [bbd_pkg::COORD_W-1:0] row;
      logic                        last;
   } dir_row_type;

   // ROW_PIX_TYPED items take their results from the ROW_RESULT rows right after them
   dir_row_type dir_table [0:DIR_ROWS-1] = '{
      '{ROW_CSR,       bbd_pkg::CSR_FRAME_WIDTH,   13'd0,    12'd0, 12'd0, 1'b0},
      '{ROW_CSR,       bbd_pkg::CSR_FRAME_HEIGHT,  13'd1,    12'd0, 12'd0, 1'b0},
      '{ROW_CSR,       bbd_pkg::CSR_DECIMATE_MODE, 13'd0,    12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd255,  12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd255,  12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd255,  12'd0, 12'd0, 1'b0},
      '{ROW_PIX_TYPED, CSR_NO_REG,                 13'd255,  12'd0, 12'd0, 1'b0},
      '{ROW_RESULT,    CSR_NO_REG,                 13'd255,  12'd0, 12'd0, 1'b0},
      '{ROW_RESULT,    CSR_NO_REG,                 13'd255,  12'd1, 12'd0, 1'b0},
      '{ROW_RESULT,    CSR_NO_REG,                 13'd255,  12'd0, 12'd1, 1'b0},
      '{ROW_RESULT,    CSR_NO_REG,                 13'd255,  12'd1, 12'd1, 1'b1},
      '{ROW_PIX,       CSR_NO_REG,                 13'd0,    12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd0,    12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd0,    12'd0, 12'd0, 1'b0},
      '{ROW_PIX_TYPED, CSR_NO_REG,                 13'd0,    12'd0, 12'd0, 1'b0},
      '{ROW_RESULT,    CSR_NO_REG,                 13'd0,    12'd0, 12'd0, 1'b0},
      '{ROW_RESULT,    CSR_NO_REG,                 13'd0,    12'd1, 12'd0, 1'b0},
      '{ROW_RESULT,    CSR_NO_REG,                 13'd0,    12'd0, 12'd1, 1'b0},
      '{ROW_RESULT,    CSR_NO_REG,                 13'd0,    12'd1, 12'd1, 1'b1},
      '{ROW_CSR,       bbd_pkg::CSR_FRAME_WIDTH,   13'd3,    12'd0, 12'd0, 1'b0},
      '{ROW_CSR,       bbd_pkg::CSR_FRAME_HEIGHT,  13'd3,    12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd17,   12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd200,  12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd3,    12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd128,  12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd255,  12'd0, 12'd0, 1'b0},
      '{ROW_CSR,       CSR_NO_REG,                 13'h1FFF, 12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd1,    12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd254,  12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd77,   12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd0,    12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd255,  12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd90,   12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd36,   12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd199,  12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd8,    12'd0, 12'd0, 1'b0},
      '{ROW_CSR,       bbd_pkg::CSR_FRAME_WIDTH,   13'd1,    12'd0, 12'd0, 1'b0},
      '{ROW_CSR,       bbd_pkg::CSR_FRAME_HEIGHT,  13'd0,    12'd0, 12'd0, 1'b0},
      '{ROW_CSR,       bbd_pkg::CSR_DECIMATE_MODE, 13'h0AAB, 12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd100,  12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd100,  12'd0, 12'd0, 1'b0},
      '{ROW_PIX,       CSR_NO_REG,                 13'd100,  12'd0, 12'd0, 1'b0},
      '{ROW_PIX_TYPED, CSR_NO_REG,                 13'd100,  12'd0, 12'd0, 1'b0},
      '{ROW_RESULT,    CSR_NO_REG,                 13'd100,  12'd0, 12'd0, 1'b1}
   };

   // idle percentages per pacing mode: none, sender, receiver, both
   int unsigned gap_by_mode   [4] = '{0, 66, 0, 32};
   int unsigned stall_by_mode [4] = '{0, 0, 66, 32};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       px_valid = 1'b0;
   logic [bbd_pkg::PIX_W-1:0]  px_data  = '0;
   logic                       rsp_take = 1'b0;
   logic                       csr_we   = 1'b0;
   logic [bbd_pkg::IDX_W-1:0]  csr_idx  = '0;
   logic [bbd_pkg::SIZE_W-1:0] csr_data = '0;

   int unsigned src_gap_pct    = 0;
   int unsigned sink_stall_pct = 0;
   int unsigned mismatches     = 0;
   int unsigned quiet_cycles   = 0;

   blur_result_type blurred_q [$];

   // shadow of the block: line stores, column window, position and settings
   bit [bbd_pkg::PIX_W-1:0]  row_m1_mem [bbd_pkg::MAX_WIDTH];
   bit [bbd_pkg::PIX_W-1:0]  row_m2_mem [bbd_pkg::MAX_WIDTH];
   bit [bbd_pkg::PIX_W-1:0]  win_hist [6];
   int unsigned              next_col = 0;
   int unsigned              next_row = 0;
   logic [bbd_pkg::SIZE_W-1:0] cur_width    = bbd_pkg::WIDTH_RESET;
   logic [bbd_pkg::SIZE_W-1:0] cur_height   = bbd_pkg::HEIGHT_RESET;
   logic                       cur_decimate = 1'b0;

   bbd_req_if req_if ();
   bbd_rsp_if rsp_if ();

   assign req_if.valid    = px_valid;
   assign req_if.pixel_in = px_data;
   assign rsp_if.ready    = rsp_take;

   box_blur_3x3_decimate u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_idx),
      .csr_wdata (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // s0..s2 are the column sums of the three window columns feeding this center
   function automatic void add_center(input int unsigned s0, s1, s2,
                                      input int unsigned cx, cy, w, h, input bit keep);
      int unsigned ox, oy, lastx, lasty;
      blur_result_type r;
      ox = cx;
      oy = cy;
      lastx = w - 1;
      lasty = h - 1;
      if (!keep) return;
      if (cur_decimate) begin
         if ((cx % 2) != 0 || (cy % 2) != 0) return;
         ox = cx / 2;
         oy = cy / 2;
         if (ox >= w / 2 || oy >= h / 2) return;
         lastx = 2 * (w / 2) - 2;
         lasty = 2 * (h / 2) - 2;
      end
      r.pixel = bbd_pkg::PIX_W'((s0 + s1 + s2) / 9);
      r.col   = bbd_pkg::COORD_W'(ox);
      r.row   = bbd_pkg::COORD_W'(oy);
      r.last  = (cx == lastx && cy == lasty);
      blurred_q.push_back(r);
   endfunction

   function automatic void blur_pixel(input logic [bbd_pkg::PIX_W-1:0] pix, input bit keep);
      int unsigned w, h, x, y, r, k;
      int unsigned above1, above2;
      int unsigned c [3][3];       // [column x-2, x-1, x][row top, mid, bottom]
      int unsigned full [3];
      int unsigned low [3];        // bottom edge: mid, bottom, bottom again
      w = (cur_width < 2) ? 2 :
          (cur_width > bbd_pkg::MAX_WIDTH) ? bbd_pkg::MAX_WIDTH : cur_width;
      h = (cur_height < 2) ? 2 :
          (cur_height > bbd_pkg::MAX_HEIGHT) ? bbd_pkg::MAX_HEIGHT : cur_height;
      x = (next_col >= w) ? w - 1 : next_col;
      y = (next_row >= h) ? h - 1 : next_row;
      above1 = row_m1_mem[x];
      above2 = row_m2_mem[x];
      row_m2_mem[x] = bbd_pkg::PIX_W'(above1);
      row_m1_mem[x] = pix;
      c[2][0] = (y == 1) ? above1 : above2;
      c[2][1] = above1;
      c[2][2] = pix;
      for (r = 0; r < 3; r++) begin
         c[1][r] = win_hist[r];
         c[0][r] = (x == 1) ? win_hist[r] : win_hist[3 + r];
      end
      for (k = 0; k < 3; k++) begin
         full[k] = c[k][0] + c[k][1] + c[k][2];
         low[k]  = c[k][1] + 2 * c[k][2];
      end
      if (y >= 1) begin
         if (x >= 1) add_center(full[0], full[1], full[2], x - 1, y - 1, w, h, keep);
         if (x == w - 1) add_center(full[1], full[2], full[2], w - 1, y - 1, w, h, keep);
         if (y == h - 1) begin
            if (x >= 1) add_center(low[0], low[1], low[2], x - 1, h - 1, w, h, keep);
            if (x == w - 1) add_center(low[1], low[2], low[2], w - 1, h - 1, w, h, keep);
         end
      end
      for (r = 0; r < 3; r++) begin
         win_hist[3 + r] = win_hist[r];
         win_hist[r] = bbd_pkg::PIX_W'(c[2][r]);
      end
      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end
      next_col = x;
      next_row = y;
   endfunction

   task automatic wait_idle();
      px_valid <= 1'b0;
      while (blurred_q.size() != 0) @(posedge clock);
      // last items may be row-0 pixels that produce nothing but are still in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bbd_pkg::IDX_W-1:0] idx,
                            input logic [bbd_pkg::SIZE_W-1:0] data);
      wait_idle();
      csr_we   <= 1'b1;
      csr_idx  <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         bbd_pkg::CSR_FRAME_WIDTH:   cur_width    = data;
         bbd_pkg::CSR_FRAME_HEIGHT:  cur_height   = data;
         bbd_pkg::CSR_DECIMATE_MODE: cur_decimate = data[0];
         default: ;
      endcase
      next_col = 0;
      next_row = 0;
   endtask

   task automatic send_pixel(input logic [bbd_pkg::PIX_W-1:0] pix);
      while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
         px_valid <= 1'b0;
         @(posedge clock);
      end
      px_valid <= 1'b1;
      px_data  <= pix;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic run_phase(input logic [bbd_pkg::SIZE_W-1:0] w_val, h_val, input logic dec,
                            input int unsigned count, fill);
      int unsigned i;
      logic [bbd_pkg::PIX_W-1:0] pix;
      write_csr(bbd_pkg::CSR_FRAME_WIDTH, w_val);
      write_csr(bbd_pkg::CSR_FRAME_HEIGHT, h_val);
      write_csr(bbd_pkg::CSR_DECIMATE_MODE, {(bbd_pkg::SIZE_W-1)'($urandom), dec});
      if ($urandom_range(3) == 0) write_csr(CSR_NO_REG, bbd_pkg::SIZE_W'($urandom));
      for (i = 0; i < count; i++) begin
         case (fill)
            FILL_WHITE:   pix = 8'hFF;
            FILL_BLACK:   pix = 8'h00;
            FILL_BILEVEL: pix = $urandom_range(1) ? 8'hFF : 8'h00;
            default:      pix = bbd_pkg::PIX_W'($urandom_range(255));
         endcase
         send_pixel(pix);
         blur_pixel(pix, 1'b1);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      blur_result_type want;
      rsp_take <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
      if (!reset && rsp_if.valid && rsp_take) begin
         if (blurred_q.size() == 0) begin
            $error("result with nothing pending: pixel_out %0d col %0d row %0d",
                   rsp_if.pixel_out, rsp_if.out_col, rsp_if.out_row);
            mismatches++;
         end else begin
            want = blurred_q.pop_front();
            if (rsp_if.pixel_out !== want.pixel) begin
               $error("pixel_out: expected %0d, got %0d", want.pixel, rsp_if.pixel_out);
               mismatches++;
            end
            if (rsp_if.out_col !== want.col) begin
               $error("out_col: expected %0d, got %0d", want.col, rsp_if.out_col);
               mismatches++;
            end
            if (rsp_if.out_row !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, rsp_if.out_row);
               mismatches++;
            end
            if (rsp_if.frame_last !== want.last) begin
               $error("frame_last: expected %0d, got %0d", want.last, rsp_if.frame_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((px_valid && req_if.ready) || (rsp_if.valid && rsp_take) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int unsigned i, w_eff, h_eff, count, fill, phase, random_items;
      logic [bbd_pkg::SIZE_W-1:0] w_val, h_val;
      blur_result_type typed;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++) begin
         case (dir_table[i].kind)
            ROW_CSR: write_csr(dir_table[i].idx, dir_table[i].data);
            ROW_PIX, ROW_PIX_TYPED: begin
               send_pixel(dir_table[i].data[bbd_pkg::PIX_W-1:0]);
               blur_pixel(dir_table[i].data[bbd_pkg::PIX_W-1:0], dir_table[i].kind == ROW_PIX);
            end
            default: begin
               typed.pixel = dir_table[i].data[bbd_pkg::PIX_W-1:0];
               typed.col   = dir_table[i].col;
               typed.row   = dir_table[i].row;
               typed.last  = dir_table[i].last;
               blurred_q.push_back(typed);
            end
         endcase
      end

      // small frames, mostly whole ones; some cut short and restarted by the next setup
      phase = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         src_gap_pct    = gap_by_mode[phase % 4];
         sink_stall_pct = stall_by_mode[phase % 4];
         w_val = ($urandom_range(8) == 0) ? bbd_pkg::SIZE_W'($urandom_range(1)) :
                                            bbd_pkg::SIZE_W'($urandom_range(6, 2));
         h_val = ($urandom_range(8) == 0) ? bbd_pkg::SIZE_W'($urandom_range(1)) :
                                            bbd_pkg::SIZE_W'($urandom_range(5, 2));
         w_eff = (w_val < 2) ? 2 : w_val;
         h_eff = (h_val < 2) ? 2 : h_val;
         count = $urandom_range(2, 1) * w_eff * h_eff;
         if ($urandom_range(4) == 0) count = $urandom_range(count - 1, 1);
         if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
         fill = $urandom_range(5);
         if (fill > FILL_BILEVEL) fill = FILL_RANDOM;
         run_phase(w_val, h_val, 1'($urandom_range(1)), count, fill);
         random_items += count;
         phase++;
      end

      // oversize settings saturate to the largest width or height; a short stretch of each
      src_gap_pct    = gap_by_mode[3];
      sink_stall_pct = stall_by_mode[3];
      run_phase(13'h1FFF, 13'd2, 1'b0, OVERSIZE_ITEMS, FILL_RANDOM);
      src_gap_pct    = gap_by_mode[2];
      sink_stall_pct = stall_by_mode[2];
      run_phase(13'd2, bbd_pkg::SIZE_W'($urandom_range(8191, 4097)), 1'b0, OVERSIZE_ITEMS,
                FILL_RANDOM);

      wait_idle();
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/bbd_pkg.sv
hw/rtl/bbd_req_if.sv
hw/rtl/bbd_rsp_if.sv
hw/rtl/bbd_line_store.sv
hw/rtl/bbd_window.sv
hw/rtl/bbd_result_queue.sv
hw/rtl/box_blur_3x3_decimate.sv
tb/tb_box_blur_3x3_decimate.sv
